// ===== hdl/volume_index_to_attenuation_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the volume index to attenuation core
// Clocked property checks; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef VOLUME_INDEX_TO_ATTENUATION_CORE_ASSERT_SVH
`define VOLUME_INDEX_TO_ATTENUATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check with reset disabling the property
`define VITAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define VITAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VITAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define VITAC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/vitac_pkg.sv =====
// ----------------------------------------------------------------------------
// vitac_pkg
// Types, constants and the log table generator for the attenuation core.
// ----------------------------------------------------------------------------
package vitac_pkg;

    localparam int MaxPoints = 4;
    localparam int RegPoints = 4;
    localparam logic [63:0] Log10Of2Q32 = 64'd1292913986;

    typedef enum logic [3:0] {
        CFG_INDEX_MIN  = 4'd0,
        CFG_INDEX_MAX  = 4'd1,
        CFG_POINT_CNT  = 4'd2,
        CFG_MUTE_LEVEL = 4'd3,
        CFG_POINT_0    = 4'd4,
        CFG_POINT_1    = 4'd5,
        CFG_POINT_2    = 4'd6,
        CFG_POINT_3    = 4'd7
    } t_cfg_index;

    // sideband through the index scaling divider
    typedef struct packed {
        logic mute;
        logic neg;
    } t_head;

    // sideband through the position divider and the interpolator
    typedef struct packed {
        logic               interp;
        logic signed [17:0] fixed;
        logic signed [15:0] a0;
        logic signed [16:0] d;
    } t_tail;

    // log10(1 + 9k/N) in Q16, N = 2^bits, via bitwise log2 (elaboration only)
    function automatic logic [16:0] log_entry(input int unsigned k, input int unsigned bits);
        logic [63:0]  num;
        logic [63:0]  m;
        logic [63:0]  frac;
        logic [63:0]  l2;
        logic [63:0]  prod;
        int unsigned  e;
        int           j;
        num  = (64'd1 << bits) + 64'(9 * k);
        e    = 0;
        frac = '0;
        for (j = 0; j < 62; j++) begin
            if ((num >> (j + 1)) != 64'd0) e = j + 1;
        end
        m = num << (30 - e);
        for (j = 0; j < 24; j++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l2   = (64'(e - bits) << 24) | frac;
        prod = l2 * Log10Of2Q32 + (64'd1 << 39);
        return 17'(prod >> 40);
    endfunction

endpackage

// ===== hdl/vitac_if.sv =====
// ----------------------------------------------------------------------------
// vitac channel interfaces
// Valid/ready channels for index input, attenuation output and configuration.
// ----------------------------------------------------------------------------
interface vitac_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] user_index;
    modport source (output valid, output user_index, input ready);
    modport sink   (input valid, input user_index, output ready);
endinterface

interface vitac_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] attenuation_mb;
    modport source (output valid, output attenuation_mb, input ready);
    modport sink   (input valid, input attenuation_mb, output ready);
endinterface

interface vitac_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/vitac_div.sv =====
// ----------------------------------------------------------------------------
// vitac_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module vitac_div #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_vld  [1:NUM_W];
    logic [DEN_W-1:0]  r_rem  [1:NUM_W];
    logic [DEN_W-1:0]  r_den  [1:NUM_W];
    logic [NUM_W-1:0]  r_num  [1:NUM_W];
    logic [NUM_W-1:0]  r_quot [1:NUM_W];
    logic [SIDE_W-1:0] r_side [1:NUM_W];

    for (genvar g = 1; g <= NUM_W; g++) begin : g_stage
        logic              w_vld;
        logic [DEN_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [NUM_W-1:0]  w_num;
        logic [NUM_W-1:0]  w_quot;
        logic [SIDE_W-1:0] w_side;
        logic [DEN_W:0]    w_trial;
        logic              w_ge;

        // previous stage, or the inputs for the first one
        if (g == 1) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = '0;
            assign w_den  = i_den;
            assign w_num  = i_num;
            assign w_quot = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_num  = r_num[g-1];
            assign w_quot = r_quot[g-1];
            assign w_side = r_side[g-1];
        end

        // shift in next numerator bit, subtract if it fits
        assign w_trial = {w_rem, w_num[NUM_W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? DEN_W'(w_trial - {1'b0, w_den}) : w_trial[DEN_W-1:0];
                r_den[g]  <= w_den;
                r_num[g]  <= w_num << 1;
                r_quot[g] <= {w_quot[NUM_W-2:0], w_ge};
                r_side[g] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_quot[NUM_W];
    assign o_side  = r_side[NUM_W];

endmodule

// ===== hdl/vitac_interp.sv =====
// ----------------------------------------------------------------------------
// vitac_interp
// Log curve lookup with linear interpolation, scaling of the point delta.
// ----------------------------------------------------------------------------
module vitac_interp #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [16:0]           i_x,
    input  vitac_pkg::t_tail      i_tail,
    output logic                  o_valid,
    output logic signed [17:0]    o_att
);
    import vitac_pkg::*;

    localparam int N  = 1 << LOG_TABLE_BITS;
    localparam int SH = 16 - LOG_TABLE_BITS;

    logic [16:0]             w_tab [0:N];
    logic [LOG_TABLE_BITS:0] w_k;
    logic [LOG_TABLE_BITS:0] w_k1;
    logic [16:0]             w_t0;
    logic [16:0]             w_t1;

    logic                    r_c_vld;
    logic [16:0]             r_c_t0;
    logic [16:0]             r_c_dt;
    logic [SH-1:0]           r_c_fr;
    t_tail                   r_c_tail;

    logic [16+SH:0]          w_sum;
    logic                    r_d_vld;
    logic [16:0]             r_d_f;
    t_tail                   r_d_tail;

    logic signed [34:0]      w_p;
    logic                    r_e_vld;
    logic signed [34:0]      r_e_p;
    t_tail                   r_e_tail;
    logic signed [18:0]      w_att;

    // constant log table
    for (genvar g = 0; g <= N; g++) begin : g_tab
        assign w_tab[g] = log_entry(g, LOG_TABLE_BITS);
    end

    // stage C: table lookup of both neighbors
    assign w_k  = i_x[16:SH];
    assign w_k1 = (LOG_TABLE_BITS+1)'(w_k + 1'b1);
    assign w_t0 = w_tab[w_k];
    assign w_t1 = (w_k < (LOG_TABLE_BITS+1)'(N)) ? w_tab[w_k1] : w_t0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= i_valid;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_t0   <= w_t0;
            r_c_dt   <= w_t1 - w_t0;
            r_c_fr   <= i_x[SH-1:0];
            r_c_tail <= i_tail;
        end
    end

    // stage D: interpolate between entries, round half up
    assign w_sum = (17+SH)'(r_c_dt * r_c_fr) + (17+SH)'(1 << (SH - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_f    <= r_c_t0 + 17'(w_sum >> SH);
            r_d_tail <= r_c_tail;
        end
    end

    // stage E: scale the attenuation delta by the log factor
    assign w_p = $signed({1'b0, r_d_f}) * r_d_tail.d + 35'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_p    <= w_p;
            r_e_tail <= r_d_tail;
        end
    end

    // floor divide by 2^16 and offset from the lower point
    assign w_att   = {{3{r_e_tail.a0[15]}}, r_e_tail.a0} + r_e_p[34:16];
    assign o_valid = r_e_vld;
    assign o_att   = r_e_tail.interp ? w_att[17:0] : r_e_tail.fixed;

endmodule

// ===== hdl/volume_index_to_attenuation_core.sv =====
// ----------------------------------------------------------------------------
// volume_index_to_attenuation_core
// Maps a user volume index onto a piecewise log curve, result in millibels.
// ----------------------------------------------------------------------------
//  port     dir  kind     payload
//  i_in     in   stream   user_index [7:0]
//  o_out    out  stream   attenuation_mb [17:0] signed
//  i_cfg    in   write    index [3:0], data [23:0]
//
//  One index per cycle while the output is not held. Stages: input stage,
//  16-bit scaling divider, curve search, 24-bit position divider, three
//  interpolation stages and the output register. Synchronous active-low reset
//  clears all valid bits and loads the register defaults. When the output
//  register is held, the whole pipeline freezes and the input is not ready.
// ----------------------------------------------------------------------------
module volume_index_to_attenuation_core #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vitac_in_if.sink    i_in,
    vitac_out_if.source o_out,
    vitac_cfg_if.sink   i_cfg
);
    import vitac_pkg::*;

    `include "volume_index_to_attenuation_core_assert.svh"

    // configuration registers
    logic [7:0]         r_index_min;
    logic [7:0]         r_index_max;
    logic [2:0]         r_point_cnt;
    logic [17:0]        r_mute;
    logic [23:0]        r_point [0:RegPoints-1];

    logic               w_en;
    logic               w_in_xfer;

    // stage A
    logic [7:0]         w_lo;
    logic [7:0]         w_hi;
    logic [2:0]         w_n;
    logic [1:0]         w_last;
    logic [7:0]         w_u;
    logic [7:0]         w_uc;
    logic signed [9:0]  w_steps;
    logic [8:0]         w_mag;
    logic [15:0]        w_num;
    logic [7:0]         w_den;
    t_head              w_head;
    logic               r_a_vld;
    logic [15:0]        r_a_num;
    logic [7:0]         r_a_den;
    t_head              r_a_head;

    logic               w_d1_vld;
    logic [15:0]        w_d1_q;
    logic [1:0]         w_d1_side;
    t_head              w_d1_head;

    // stage B
    logic signed [17:0] w_vol;
    logic signed [15:0] w_att [0:RegPoints-1];
    logic [7:0]         w_idx [0:RegPoints-1];
    logic [2:0]         w_pos;
    logic [1:0]         w_pl;
    logic [1:0]         w_ph;
    t_tail              w_tail;
    logic [7:0]         w_off;
    logic [7:0]         w_span;
    logic               r_b_vld;
    logic [7:0]         r_b_off;
    logic [7:0]         r_b_span;
    t_tail              r_b_tail;

    logic               w_d2_vld;
    logic [23:0]        w_d2_q;
    logic [$bits(t_tail)-1:0] w_d2_side;

    logic               w_ip_vld;
    logic signed [17:0] w_ip_att;
    logic               r_o_vld;
    logic signed [17:0] r_o_att;

    // global advance: output register free or being taken
    assign w_en      = !r_o_vld || o_out.ready;
    assign w_in_xfer = i_in.valid && w_en;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_min <= 8'd0;
            r_index_max <= 8'd100;
            r_point_cnt <= 3'd4;
            r_mute      <= 18'(-75800);
            r_point[0]  <= 24'd15369217;
            r_point[1]  <= 24'd15676436;
            r_point[2]  <= 24'd16470102;
            r_point[3]  <= 24'd100;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_INDEX_MIN:  r_index_min <= i_cfg.data[7:0];
                CFG_INDEX_MAX:  r_index_max <= i_cfg.data[7:0];
                CFG_POINT_CNT:  r_point_cnt <= i_cfg.data[2:0];
                CFG_MUTE_LEVEL: r_mute      <= i_cfg.data[17:0];
                CFG_POINT_0:    r_point[0]  <= i_cfg.data;
                CFG_POINT_1:    r_point[1]  <= i_cfg.data;
                CFG_POINT_2:    r_point[2]  <= i_cfg.data;
                CFG_POINT_3:    r_point[3]  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < RegPoints; g++) begin : g_pt
        assign w_idx[g] = r_point[g][7:0];
        assign w_att[g] = $signed(r_point[g][23:8]);
    end

    // stage A: clamp range and index, build the scaling product
    always_comb begin
        w_lo   = r_index_min;
        w_hi   = (r_index_max < r_index_min) ? r_index_min : r_index_max;
        if (r_point_cnt == 3'd0) begin
            w_n = 3'd1;
        end else if (r_point_cnt > 3'(MaxPoints)) begin
            w_n = 3'(MaxPoints);
        end else begin
            w_n = r_point_cnt;
        end
        w_last = 2'(w_n - 3'd1);
        w_u    = i_in.user_index;
        if (w_u < w_lo) begin
            w_uc = w_lo;
        end else if (w_u > w_hi) begin
            w_uc = w_hi;
        end else begin
            w_uc = w_u;
        end
        w_steps = 10'sd1 + $signed({2'b00, w_idx[w_last]}) - $signed({2'b00, w_idx[0]});
        w_mag   = w_steps[9] ? 9'(-w_steps) : w_steps[8:0];
        w_head.mute = (w_u < w_lo) && (w_u == 8'd0);
        if (w_lo == w_hi) begin
            w_num      = {8'd0, w_lo};
            w_den      = 8'd1;
            w_head.neg = 1'b0;
        end else begin
            w_num      = 16'(w_mag * (w_uc - w_lo));
            w_den      = w_hi - w_lo;
            w_head.neg = w_steps[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= w_in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_num  <= w_num;
            r_a_den  <= w_den;
            r_a_head <= w_head;
        end
    end

    vitac_div #(
        .NUM_W  (16),
        .DEN_W  (8),
        .SIDE_W ($bits(t_head))
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_vld),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_side  (r_a_head),
        .o_valid (w_d1_vld),
        .o_quot  (w_d1_q),
        .o_side  (w_d1_side)
    );

    assign w_d1_head = t_head'(w_d1_side);

    // stage B: find the curve segment and pick the result kind
    always_comb begin
        w_vol = w_d1_head.neg ? -$signed({2'b00, w_d1_q}) : $signed({2'b00, w_d1_q});
        w_pos = w_n;
        for (int i = RegPoints - 1; i >= 0; i--) begin
            if ((3'(i) < w_n) && ($signed({10'd0, w_idx[i]}) >= w_vol)) w_pos = 3'(i);
        end
        w_ph   = w_pos[1:0];
        w_pl   = 2'(w_pos - 3'd1);
        w_off  = 8'(w_vol - $signed({10'd0, w_idx[w_pl]}));
        w_span = w_idx[w_ph] - w_idx[w_pl];
        w_tail.interp = 1'b0;
        w_tail.a0     = w_att[w_pl];
        w_tail.d      = 17'(w_att[w_ph]) - 17'(w_att[w_pl]);
        if (w_d1_head.mute) begin
            w_tail.fixed = $signed(r_mute);
        end else if (w_pos >= w_n) begin
            w_tail.fixed = 18'(w_att[w_last]);
        end else if (w_pos == 3'd0) begin
            w_tail.fixed = (w_vol == $signed({10'd0, w_idx[0]})) ? 18'(w_att[0])
                                                                 : $signed(r_mute);
        end else begin
            w_tail.fixed  = 18'(w_att[w_pl]);
            w_tail.interp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_off  <= w_tail.interp ? w_off : 8'd0;
            r_b_span <= w_tail.interp ? w_span : 8'd1;
            r_b_tail <= w_tail;
        end
    end

    // position within the segment in Q1.16
    vitac_div #(
        .NUM_W  (24),
        .DEN_W  (8),
        .SIDE_W ($bits(t_tail))
    ) u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_vld),
        .i_num   ({r_b_off, 16'd0}),
        .i_den   (r_b_span),
        .i_side  (r_b_tail),
        .o_valid (w_d2_vld),
        .o_quot  (w_d2_q),
        .o_side  (w_d2_side)
    );

    vitac_interp #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_vld),
        .i_x     (w_d2_q[16:0]),
        .i_tail  (t_tail'(w_d2_side)),
        .o_valid (w_ip_vld),
        .o_att   (w_ip_att)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= w_ip_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_att <= w_ip_att;
        end
    end

    assign o_out.valid          = r_o_vld;
    assign o_out.attenuation_mb = r_o_att;

    `VITAC_ASSERT(a_seg_offset_in_span, i_clk, i_rst_n, (r_b_vld && r_b_tail.interp) |-> (r_b_off != 8'd0 && r_b_off <= r_b_span), "segment offset outside span")
    `VITAC_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !w_en |-> r_o_vld, "pipeline stalled with empty output")
    `VITAC_ASSERT(a_zero_index_mutes, i_clk, i_rst_n, (w_in_xfer && i_in.user_index == 8'd0 && r_index_min != 8'd0) |=> (r_a_vld && r_a_head.mute), "zero index below range not muted")

endmodule

// ===== tb/tb_volume_index_to_attenuation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_index_to_attenuation_core
// Self-checking bench for the volume curve core. Runs directed and random
// user indices through several register settings and compares each output
// against a bit-exact predictor of the curve lookup and log interpolation,
// under random source idling, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_volume_index_to_attenuation_core;
    import vitac_pkg::*;

    localparam int TableBits = 8;
    localparam int TableSize = 1 << TableBits;
    localparam int PipeDepth = 46;
    localparam int PhaseItems = 135;

    logic clk;
    logic rst_n;

    vitac_in_if  in_ch ();
    vitac_out_if out_ch ();
    vitac_cfg_if cfg_ch ();

    volume_index_to_attenuation_core #(
        .LOG_TABLE_BITS(TableBits)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // shadow copy of the register file
    logic [7:0]  sh_min;
    logic [7:0]  sh_max;
    logic [2:0]  sh_count;
    logic [17:0] sh_mute;
    logic [23:0] sh_point [RegPoints];

    logic [16:0] log_q16 [TableSize + 1];

    logic [7:0]         index_queue [$];
    logic signed [17:0] atten_queue [$];

    int  idle_mode;     // 0 none, 1 source idles, 2 sink stalls, 3 both
    bit  in_taken;
    bit  hold_start;
    bit  hold_taken;
    int  hold_left;
    int  items_sent;
    int  results_seen;
    int  mismatches;
    int  phases_run;

    // clock
    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // log10(1 + 9k/N) in Q16 via bitwise log2 with 24 fractional bits
    function automatic logic [16:0] log_factor_q16(input int unsigned k);
        logic [63:0] num;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] l2;
        int unsigned e;
        num  = 64'(TableSize) + 64'(9 * k);
        e    = 0;
        frac = '0;
        while ((num >> (e + 1)) != 64'd0) e++;
        m = num << (30 - e);
        repeat (24) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l2 = (64'(e - TableBits) << 24) | frac;
        return 17'((l2 * 64'd1292913986 + (64'd1 << 39)) >> 40);
    endfunction

    // expected attenuation for one user index under the shadow registers
    function automatic logic signed [17:0] predict_attenuation(input logic [7:0] user);
        int     lo;
        int     hi;
        int     ui;
        int     n;
        int     vol;
        int     pos;
        int     steps;
        int     curve_idx [RegPoints];
        longint curve_att [RegPoints];
        longint off;
        longint span;
        longint x;
        longint k;
        longint fr;
        longint t0;
        longint t1;
        longint f;
        longint p;
        lo = sh_min;
        hi = sh_max;
        ui = user;
        n  = sh_count;
        if (hi < lo) hi = lo;
        if (n < 1) n = 1;
        if (n > MaxPoints) n = MaxPoints;
        for (int i = 0; i < RegPoints; i++) begin
            curve_idx[i] = sh_point[i][7:0];
            curve_att[i] = longint'($signed(sh_point[i][23:8]));
        end
        if (ui < lo) begin
            if (ui == 0) return $signed(sh_mute);
            ui = lo;
        end else if (ui > hi) begin
            ui = hi;
        end
        if (lo == hi) begin
            vol = lo;
        end else begin
            steps = 1 + curve_idx[n-1] - curve_idx[0];
            vol   = (steps * (ui - lo)) / (hi - lo);
        end
        pos = n;
        for (int i = n - 1; i >= 0; i--) begin
            if (curve_idx[i] >= vol) pos = i;
        end
        if (pos >= n) return 18'(curve_att[n-1]);
        if (pos == 0) return (vol == curve_idx[0]) ? 18'(curve_att[0]) : $signed(sh_mute);
        // log interpolation between the two neighboring points
        off  = vol - curve_idx[pos-1];
        span = curve_idx[pos] - curve_idx[pos-1];
        x    = (off << 16) / span;
        k    = x >> (16 - TableBits);
        fr   = x & ((1 << (16 - TableBits)) - 1);
        t0   = log_q16[k];
        t1   = (k < TableSize) ? log_q16[k+1] : t0;
        f    = t0 + (((t1 - t0) * fr + (1 << (15 - TableBits))) >> (16 - TableBits));
        p    = f * (curve_att[pos] - curve_att[pos-1]) + 32768;
        return 18'(curve_att[pos-1] + (p >>> 16));
    endfunction

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // source side: offer the next queued index
    always @(negedge clk) begin
        logic       nxt_valid;
        logic [7:0] nxt_index;
        if (rst_n && (!in_ch.valid || in_taken)) begin
            nxt_valid = 1'b0;
            nxt_index = in_ch.user_index;
            if (index_queue.size() > 0 &&
                !((idle_mode == 1 && coin(75)) || (idle_mode == 3 && coin(9)))) begin
                nxt_index = index_queue.pop_front();
                nxt_valid = 1'b1;
            end
            in_ch.valid      <= nxt_valid;
            in_ch.user_index <= nxt_index;
        end
        in_taken = 1'b0;
    end

    // input transfers feed the predictor
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            atten_queue.push_back(predict_attenuation(in_ch.user_index));
            in_taken = 1'b1;
            items_sent++;
        end
    end

    // sink side: random stalls and the long hold-off
    always @(negedge clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !((idle_mode == 2 && coin(75)) || (idle_mode == 3 && coin(9)));
        end
    end

    // output checker
    always @(posedge clk) begin
        logic signed [17:0] want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (atten_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result attenuation_mb=%0d", out_ch.attenuation_mb);
            end else begin
                want = atten_queue.pop_front();
                if (out_ch.attenuation_mb !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch attenuation_mb: expected %0d got %0d",
                                 want, out_ch.attenuation_mb);
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [23:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            CFG_INDEX_MIN:  sh_min   = value[7:0];
            CFG_INDEX_MAX:  sh_max   = value[7:0];
            CFG_POINT_CNT:  sh_count = value[2:0];
            CFG_MUTE_LEVEL: sh_mute  = value[17:0];
            CFG_POINT_0:    sh_point[0] = value;
            CFG_POINT_1:    sh_point[1] = value;
            CFG_POINT_2:    sh_point[2] = value;
            default:        sh_point[3] = value;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_curve(input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] c, input logic [7:0] d,
                               input bit extreme_att);
        logic [15:0] att [4];
        for (int i = 0; i < 4; i++) att[i] = 16'($urandom);
        if (extreme_att) begin
            att[0] = 16'h8000;
            att[3] = 16'h7FFF;
        end
        write_reg(CFG_POINT_0, {att[0], a});
        write_reg(CFG_POINT_1, {att[1], b});
        write_reg(CFG_POINT_2, {att[2], c});
        write_reg(CFG_POINT_3, {att[3], d});
    endtask

    // wait until every queued index has produced its result
    task automatic drain();
        while (index_queue.size() > 0 || in_ch.valid || atten_queue.size() > 0)
            @(posedge clk);
        repeat (PipeDepth + 10) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_index();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return sh_min;
            2:       return sh_max;
            3:       return sh_min - 8'd1;
            4:       return sh_max + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [7:0] p [4];
        logic [7:0] tmp;
        int lo_sel;
        lo_sel = $urandom_range(3);
        write_reg(CFG_INDEX_MIN, 24'(lo_sel == 0 ? 0 : (lo_sel == 1 ? 255 : $urandom_range(60))));
        write_reg(CFG_INDEX_MAX, 24'(coin(15) ? $urandom_range(255) :
                                     (coin(20) ? 255 : sh_min + $urandom_range(255 - sh_min))));
        write_reg(CFG_POINT_CNT, 24'(coin(70) ? $urandom_range(2, 4) : $urandom_range(7)));
        write_reg(CFG_MUTE_LEVEL, 24'(18'(-$urandom_range(75800))) | (24'($urandom) & 24'hFC0000));
        for (int i = 0; i < 4; i++) p[i] = 8'($urandom_range(coin(50) ? 120 : 255));
        if (coin(85)) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3 - i; j++)
                    if (p[j] > p[j+1]) begin
                        tmp = p[j]; p[j] = p[j+1]; p[j+1] = tmp;
                    end
        end
        write_curve(p[0], p[1], p[2], p[3], coin(25));
    endtask

    // stimulus sequence
    initial begin
        static logic [7:0] directed [] = '{8'd0, 8'd1, 8'd2, 8'd19, 8'd20, 8'd21, 8'd50,
                                           8'd85, 8'd86, 8'd99, 8'd100, 8'd101, 8'd128,
                                           8'd254, 8'd255};
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.user_index = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_INDEX_MIN;
        cfg_ch.data      = '0;
        idle_mode        = 0;
        in_taken         = 1'b0;
        hold_start       = 1'b0;
        hold_taken       = 1'b0;
        hold_left        = 0;
        items_sent       = 0;
        results_seen     = 0;
        mismatches       = 0;
        phases_run       = 0;
        sh_min           = 8'd0;
        sh_max           = 8'd100;
        sh_count         = 3'd4;
        sh_mute          = 18'(-75800);
        sh_point[0]      = 24'd15369217;
        sh_point[1]      = 24'd15676436;
        sh_point[2]      = 24'd16470102;
        sh_point[3]      = 24'd100;
        for (int k = 0; k <= TableSize; k++) log_q16[k] = log_factor_q16(k);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset curve, edges of the default points
        foreach (directed[i]) index_queue.push_back(directed[i]);
        drain();

        // full range, zero mute, extreme attenuations
        write_reg(CFG_INDEX_MIN, 24'd0);
        write_reg(CFG_INDEX_MAX, 24'd255);
        write_reg(CFG_MUTE_LEVEL, 24'd0);
        write_curve(8'd0, 8'd1, 8'd128, 8'd255, 1'b1);
        index_queue.push_back(8'd0);
        index_queue.push_back(8'd1);
        index_queue.push_back(8'd128);
        index_queue.push_back(8'd255);
        drain();

        // reversed range, count zero, then single-index range and count above max
        write_reg(CFG_INDEX_MIN, 24'd200);
        write_reg(CFG_INDEX_MAX, 24'd10);
        write_reg(CFG_POINT_CNT, 24'd0);
        write_reg(CFG_MUTE_LEVEL, 24'(18'(-75800)));
        index_queue.push_back(8'd0);
        index_queue.push_back(8'd199);
        index_queue.push_back(8'd250);
        drain();
        write_reg(CFG_INDEX_MIN, 24'd30);
        write_reg(CFG_INDEX_MAX, 24'd30);
        write_reg(CFG_POINT_CNT, 24'd7);
        write_curve(8'd40, 8'd10, 8'd90, 8'd20, 1'b0);   // unsorted
        index_queue.push_back(8'd0);
        index_queue.push_back(8'd30);
        index_queue.push_back(8'd31);
        drain();

        // random phases, cycling the flow-control modes
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            idle_mode = ph % 4;
            for (int i = 0; i < PhaseItems; i++) index_queue.push_back(pick_index());
            if (ph == 4) hold_start = 1'b1;
            drain();
            phases_run++;
        end

        $display("Covered %0d indices, %0d results, %0d random register settings,",
                 items_sent, results_seen, phases_run);
        $display("with source idling, sink stalls and one long sink hold-off.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
